// ===== src/reciprocal_lattice_voxel_accumulator_assert.svh =====
// assertion macros for the voxel accumulator
// used by the top level, no other dependencies
`ifndef RECIPROCAL_LATTICE_VOXEL_ACCUMULATOR_ASSERT_SVH
`define RECIPROCAL_LATTICE_VOXEL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define RLVA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define RLVA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== src/rlva_pkg.sv =====
// shared types and constants of the voxel accumulator
// no dependencies
package rlva_pkg;

  localparam int DEF_X_VOXELS = 32;
  localparam int DEF_Y_VOXELS = 32;
  localparam int DEF_Z_VOXELS = 32;
  localparam int STORE_DEPTH  = 32768;
  localparam int ADDR_W       = 15;
  localparam int SUM_W        = 48;
  localparam int CNT_W        = 32;
  localparam int PADDR_W      = 6;
  localparam int PDATA_W      = 64;

  // register indexes
  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_PPK     = 3'd1;
  localparam logic [2:0] REG_SCALE   = 3'd2;
  localparam logic [2:0] REG_OFFSET  = 3'd3;
  localparam logic [2:0] REG_IGNORE  = 3'd4;
  localparam logic [2:0] REG_ROW_A   = 3'd5;
  localparam logic [2:0] REG_ROW_B   = 3'd6;
  localparam logic [2:0] REG_ROW_C   = 3'd7;

  // value modes
  localparam logic [1:0] MODE_RAW       = 2'd0;
  localparam logic [1:0] MODE_CORRECTED = 2'd1;
  localparam logic [1:0] MODE_SCALE     = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  typedef struct packed {
    logic               hkl_filter;
    logic [1:0]         mode;
    logic [3:0]         ppk;
    logic [23:0]        scale;
    logic signed [15:0] offset;
    logic signed [15:0] skip_value;
    logic [59:0]        row_a;
    logic [59:0]        row_b;
    logic [59:0]        row_c;
  } rlva_cfg_t;

endpackage

// ===== src/rlva_if.sv =====
// request and response channel interfaces of the voxel accumulator
// no dependencies
interface rlva_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [23:0] scatter_x;
  logic signed [23:0] scatter_y;
  logic signed [23:0] scatter_z;
  logic signed [15:0] raw_value;
  logic signed [15:0] corrected_value;
  logic signed [15:0] filtered_value;
  logic [23:0]        correction;
  logic [14:0]        read_index;

  modport source (output valid, req_type, scatter_x, scatter_y, scatter_z, raw_value,
                  corrected_value, filtered_value, correction, read_index, input ready);
  modport sink (input valid, req_type, scatter_x, scatter_y, scatter_z, raw_value,
                corrected_value, filtered_value, correction, read_index, output ready);
endinterface

interface rlva_rsp_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [14:0]        voxel_index;
  logic signed [47:0] voxel_sum;
  logic [31:0]        voxel_count;

  modport source (output valid, accepted, voxel_index, voxel_sum, voxel_count,
                  input ready);
  modport sink (input valid, accepted, voxel_index, voxel_sum, voxel_count,
                output ready);
endinterface

// ===== src/rlva_cfg.sv =====
// apb configuration register file of the voxel accumulator
// depends on rlva_pkg
module rlva_cfg import rlva_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output rlva_cfg_t          cfg
);

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[5:3];
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hkl_filter <= 1'b0;
      cfg.mode       <= MODE_RAW;
      cfg.ppk        <= 4'd1;
      cfg.scale      <= 24'd65536;
      cfg.offset     <= '0;
      cfg.skip_value <= -16'sd1;
      cfg.row_a      <= '0;
      cfg.row_b      <= '0;
      cfg.row_c      <= '0;
    end else if (wr) begin
      case (idx)
        REG_CONTROL: begin
          cfg.hkl_filter <= pwdata[0];
          cfg.mode       <= pwdata[2:1];
        end
        REG_PPK:    cfg.ppk        <= pwdata[3:0];
        REG_SCALE:  cfg.scale      <= pwdata[23:0];
        REG_OFFSET: cfg.offset     <= pwdata[15:0];
        REG_IGNORE: cfg.skip_value <= pwdata[15:0];
        REG_ROW_A:  cfg.row_a      <= pwdata[59:0];
        REG_ROW_B:  cfg.row_b      <= pwdata[59:0];
        REG_ROW_C:  cfg.row_c      <= pwdata[59:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CONTROL: prdata = {61'd0, cfg.mode, cfg.hkl_filter};
      REG_PPK:     prdata = {60'd0, cfg.ppk};
      REG_SCALE:   prdata = {40'd0, cfg.scale};
      REG_OFFSET:  prdata = {48'd0, cfg.offset};
      REG_IGNORE:  prdata = {48'd0, cfg.skip_value};
      REG_ROW_A:   prdata = {4'd0, cfg.row_a};
      REG_ROW_B:   prdata = {4'd0, cfg.row_b};
      REG_ROW_C:   prdata = {4'd0, cfg.row_c};
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== src/reciprocal_lattice_voxel_accumulator.sv =====
// top level of the reciprocal lattice voxel accumulator: sequencer, shared multiplier,
// voxel store; depends on rlva_pkg, rlva_if, rlva_cfg and the assertion header
//
//  channel | dir | handshake        | transaction
//  req     | in  | valid/ready      | accumulate pixel or read voxel
//  rsp     | out | valid/ready      | accepted flag, voxel index, sum, count
//  apb     | in  | psel/penable     | register write or read, 64-bit data
//
// one shared 34x25 multiplier runs the nine dot-product terms, the gain product and
// the increment in turn
// after rst the store is zeroed one entry a cycle, all 32768 entries, req.ready low
// a finished result waits in the output register while the next item runs;
// the sequencer stalls in its last state only while that register is full
`include "reciprocal_lattice_voxel_accumulator_assert.svh"
module reciprocal_lattice_voxel_accumulator import rlva_pkg::*; #(
  parameter int X_VOXELS = DEF_X_VOXELS,
  parameter int Y_VOXELS = DEF_Y_VOXELS,
  parameter int Z_VOXELS = DEF_Z_VOXELS
) (
  input  logic               clk,
  input  logic               rst,
  rlva_req_if.sink           req,
  rlva_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  // voxel centre offsets and address strides, reduced to the store size
  localparam int CW = 24;
  localparam logic signed [CW-1:0] C0_X = CW'((X_VOXELS - 2) / 2);
  localparam logic signed [CW-1:0] C0_Y = CW'((Y_VOXELS - 2) / 2);
  localparam logic signed [CW-1:0] C0_Z = CW'((Z_VOXELS - 2) / 2);
  localparam logic signed [CW-1:0] LIM_X = CW'(X_VOXELS);
  localparam logic signed [CW-1:0] LIM_Y = CW'(Y_VOXELS);
  localparam logic signed [CW-1:0] LIM_Z = CW'(Z_VOXELS);
  localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(X_VOXELS % STORE_DEPTH);
  localparam logic [ADDR_W-1:0] STRIDE_Z = ADDR_W'((X_VOXELS * Y_VOXELS) % STORE_DEPTH);

  typedef enum logic [9:0] {
    ST_CLR   = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_DOT   = 10'b0000000100,
    ST_SCALE = 10'b0000001000,
    ST_FAC   = 10'b0000010000,
    ST_CHECK = 10'b0000100000,
    ST_INC   = 10'b0001000000,
    ST_WB    = 10'b0010000000,
    ST_RD    = 10'b0100000000,
    ST_OUT   = 10'b1000000000
  } state_t;

  rlva_cfg_t cfg;

  rlva_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  state_t state;
  logic [ADDR_W-1:0] clr_cnt;

  // item registers
  logic signed [23:0] it_s [3];
  logic signed [16:0] it_d;
  logic signed [15:0] it_flt;
  logic [23:0]        it_corr;
  logic [1:0]         row_cnt, col_cnt, ax_cnt;
  logic signed [45:0] h_acc [3];
  logic signed [CW-1:0] coord [3];
  logic [2:0]         far_r;
  logic [32:0]        f_r;
  logic signed [50:0] inc_r;
  logic [ADDR_W-1:0]  addr_r;

  // pending result and output register
  logic               res_acc;
  logic [ADDR_W-1:0]  res_idx;
  logic signed [SUM_W-1:0] res_sum;
  logic [CNT_W-1:0]   res_cnt;
  logic               out_valid;
  logic               out_acc;
  logic [ADDR_W-1:0]  out_idx;
  logic signed [SUM_W-1:0] out_sum;
  logic [CNT_W-1:0]   out_cnt;

  // voxel store: sum and count side by side
  logic [SUM_W+CNT_W-1:0] mem [STORE_DEPTH];
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_wa, mem_ra;
  logic [SUM_W+CNT_W-1:0] mem_wd, mem_q;
  logic signed [SUM_W-1:0] rd_sum;
  logic [CNT_W-1:0]        rd_cnt;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  assign rd_sum = mem_q[SUM_W+CNT_W-1:CNT_W];
  assign rd_cnt = mem_q[CNT_W-1:0];

  logic req_fire;
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid & req.ready;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [58:0] mul_p;
  logic [19:0]        elem;
  logic [59:0]        row_sel;

  always_comb begin
    case (row_cnt)
      2'd0:    row_sel = cfg.row_a;
      2'd1:    row_sel = cfg.row_b;
      default: row_sel = cfg.row_c;
    endcase
    case (col_cnt)
      2'd0:    elem = row_sel[19:0];
      2'd1:    elem = row_sel[39:20];
      default: elem = row_sel[59:40];
    endcase
    mul_a = 34'(it_s[col_cnt]);
    mul_b = 25'($signed(elem));
    case (state)
      ST_FAC: begin
        mul_a = $signed({10'd0, cfg.scale});
        mul_b = $signed({1'b0, it_corr});
      end
      ST_INC: begin
        mul_b = 25'(it_d);
        if (cfg.mode == MODE_CORRECTED) begin
          mul_a = $signed({10'd0, cfg.scale});
        end else begin
          mul_a = $signed({1'b0, f_r});
        end
      end
      default: ;
    endcase
    mul_p = 59'(mul_a) * 59'(mul_b);
  end

  // scaling and rounding of one axis
  logic signed [45:0] h_sel;
  logic signed [50:0] hp, hp_mag;
  logic signed [CW-1:0] rnd;
  logic [27:0]        frac;
  logic               far_now;

  always_comb begin
    h_sel   = h_acc[ax_cnt];
    hp      = 51'(h_sel) * $signed({47'd0, cfg.ppk});
    hp_mag  = hp[50] ? -hp : hp;
    rnd     = CW'((hp_mag + 51'sd134217728) >>> 28);
    if (hp[50]) begin
      rnd = -rnd;
    end
    frac    = h_sel[27:0];
    far_now = (frac >= 28'h4000000) && (frac <= 28'hC000000);
  end

  // bounds, validity and address
  logic signed [CW-1:0] vx, vy, vz;
  logic                 in_box, pix_ok;
  logic [ADDR_W-1:0]    vox_addr;

  always_comb begin
    vx     = coord[0] + C0_X;
    vy     = coord[1] + C0_Y;
    vz     = coord[2] + C0_Z;
    in_box = (vx >= 0) && (vx < LIM_X) && (vy >= 0) && (vy < LIM_Y) &&
             (vz >= 0) && (vz < LIM_Z);
    pix_ok = (!cfg.hkl_filter || (far_r != 3'b000)) && in_box &&
             (it_flt > 16'sd0) && (it_flt != cfg.skip_value);
    vox_addr = ADDR_W'(vz[ADDR_W-1:0] * STRIDE_Z + vy[ADDR_W-1:0] * STRIDE_Y +
                       vx[ADDR_W-1:0]);
  end

  // saturating update
  logic signed [51:0] sum_wide;
  logic signed [SUM_W-1:0] sum_sat;
  logic [CNT_W-1:0]   cnt_next;

  always_comb begin
    sum_wide = 52'(rd_sum) + 52'(inc_r);
    if (sum_wide > 52'sh7FFFFFFFFFFF) begin
      sum_sat = 48'sh7FFFFFFFFFFF;
    end else if (sum_wide < -52'sh800000000000) begin
      sum_sat = 48'sh800000000000;
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    cnt_next = (rd_cnt == '1) ? rd_cnt : rd_cnt + 1'b1;
  end

  // store port selection
  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = {sum_sat, cnt_next};
    mem_re = 1'b0;
    mem_ra = vox_addr;
    if (state == ST_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_cnt;
      mem_wd = '0;
    end else if (state == ST_WB) begin
      mem_we = 1'b1;
    end
    if (req_fire && req.req_type) begin
      mem_re = 1'b1;
      mem_ra = req.read_index;
    end else if (state == ST_CHECK && pix_ok) begin
      mem_re = 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_fire) begin
            state <= req.req_type ? ST_RD : ST_DOT;
          end
        end
        ST_DOT: begin
          if (row_cnt == 2'd2 && col_cnt == 2'd2) begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (ax_cnt == 2'd2) begin
            state <= ST_FAC;
          end
        end
        ST_FAC:   state <= ST_CHECK;
        ST_CHECK: state <= pix_ok ? ST_INC : ST_OUT;
        ST_INC:   state <= ST_WB;
        ST_WB:    state <= ST_OUT;
        ST_RD:    state <= ST_OUT;
        ST_OUT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          it_s[0]  <= req.scatter_x;
          it_s[1]  <= req.scatter_y;
          it_s[2]  <= req.scatter_z;
          it_flt   <= req.filtered_value;
          it_corr  <= req.correction;
          addr_r   <= req.read_index;
          row_cnt  <= 2'd0;
          col_cnt  <= 2'd0;
          ax_cnt   <= 2'd0;
          h_acc[0] <= '0;
          h_acc[1] <= '0;
          h_acc[2] <= '0;
          case (cfg.mode)
            MODE_RAW:       it_d <= 17'(req.raw_value) - 17'(cfg.offset);
            MODE_CORRECTED: it_d <= 17'(req.corrected_value) - 17'(cfg.offset);
            default:        it_d <= 17'(req.filtered_value) - 17'(cfg.offset);
          endcase
        end
      end
      ST_DOT: begin
        h_acc[row_cnt] <= h_acc[row_cnt] + 46'(mul_p);
        if (col_cnt == 2'd2) begin
          col_cnt <= 2'd0;
          row_cnt <= row_cnt + 1'b1;
        end else begin
          col_cnt <= col_cnt + 1'b1;
        end
      end
      ST_SCALE: begin
        coord[ax_cnt] <= rnd;
        far_r[ax_cnt] <= far_now;
        ax_cnt        <= ax_cnt + 1'b1;
      end
      ST_FAC: f_r <= 33'((mul_p + 59'sd32768) >>> 16);
      ST_CHECK: begin
        addr_r <= vox_addr;
        if (!pix_ok) begin
          res_acc <= 1'b0;
          res_idx <= '0;
          res_sum <= '0;
          res_cnt <= '0;
        end
      end
      ST_INC: inc_r <= (cfg.mode == MODE_NONE) ? 51'sd0 : 51'(mul_p);
      ST_WB: begin
        res_acc <= 1'b1;
        res_idx <= addr_r;
        res_sum <= sum_sat;
        res_cnt <= cnt_next;
      end
      ST_RD: begin
        res_acc <= 1'b1;
        res_idx <= addr_r;
        res_sum <= rd_sum;
        res_cnt <= rd_cnt;
      end
      ST_OUT: begin
        if (!out_valid || rsp.ready) begin
          out_acc <= res_acc;
          out_idx <= res_idx;
          out_sum <= res_sum;
          out_cnt <= res_cnt;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.accepted    = out_acc;
  assign rsp.voxel_index = out_idx;
  assign rsp.voxel_sum   = out_sum;
  assign rsp.voxel_count = out_cnt;

  // store is only written by the clearing pass or a write-back
  `RLVA_ASSERT_NOW(a_we_src, clk, rst, mem_we, (state == ST_CLR) || (state == ST_WB))
  // a write-back never stores a zero count
  `RLVA_ASSERT_NOW(a_wb_cnt, clk, rst, state == ST_WB, cnt_next != '0)
  // a rejected pixel reports all zero fields
  `RLVA_ASSERT_NOW(a_rej_zero, clk, rst, rsp.valid && !rsp.accepted,
                   (rsp.voxel_index == '0) && (rsp.voxel_sum == '0) && (rsp.voxel_count == '0))
  // a read transaction is answered from the store read in the next cycle
  `RLVA_ASSERT_NEXT(a_rd_seq, clk, rst, req_fire && req.req_type, state == ST_RD)

endmodule
